[rtl/core/mexp_pkg.sv]
// package for the modular exponentiation unit: microcode types, program table, status struct
package mexp_pkg;

  localparam int ResultWidth = 32;
  localparam int PcWidth = 4;

  typedef logic [PcWidth-1:0] upc_t;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_INIT,
    OP_RED_STEP,
    OP_MUL_STEP,
    OP_SQ_FROM_Z,
    OP_ACC_FROM_Z,
    OP_SETUP_ACC,
    OP_SETUP_SQ,
    OP_SHIFT_E,
    OP_WRITE_OUT,
    OP_WRITE_ERR
  } dp_op_e;

  // jump conditions
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_IN,
    C_MOD_ZERO,
    C_CNT_NZ,
    C_EXP_ZERO,
    C_EXP_EVEN,
    C_EXP_ONE,
    C_OUT_FULL
  } cond_e;

  typedef struct packed {
    logic   accept;
    dp_op_e op;
    cond_e  cond;
    upc_t   target;
  } ctrl_word_t;

  typedef struct packed {
    logic mod_zero;
    logic exp_zero;
    logic exp_even;
    logic exp_one;
    logic in_valid;
    logic out_full;
  } dp_status_t;

  // program addresses
  localparam upc_t AddrFetch   = 4'd0;
  localparam upc_t AddrCheck   = 4'd1;
  localparam upc_t AddrReduce  = 4'd2;
  localparam upc_t AddrSqInit  = 4'd3;
  localparam upc_t AddrTest    = 4'd4;
  localparam upc_t AddrSetAcc  = 4'd5;
  localparam upc_t AddrMulAcc  = 4'd6;
  localparam upc_t AddrAccOut  = 4'd7;
  localparam upc_t AddrShift   = 4'd8;
  localparam upc_t AddrSetSq   = 4'd9;
  localparam upc_t AddrMulSq   = 4'd10;
  localparam upc_t AddrSqOut   = 4'd11;
  localparam upc_t AddrDone    = 4'd12;
  localparam upc_t AddrDoneRet = 4'd13;
  localparam upc_t AddrErr     = 4'd14;
  localparam upc_t AddrErrRet  = 4'd15;

  function automatic ctrl_word_t ucode_fetch(upc_t pc);
    ctrl_word_t w;
    w = '{accept: 1'b0, op: OP_NONE, cond: C_NEVER, target: AddrFetch};
    case (pc)
      AddrFetch:   w = '{accept: 1'b1, op: OP_LOAD,       cond: C_NO_IN,    target: AddrFetch};
      AddrCheck:   w = '{accept: 1'b0, op: OP_INIT,       cond: C_MOD_ZERO, target: AddrErr};
      AddrReduce:  w = '{accept: 1'b0, op: OP_RED_STEP,   cond: C_CNT_NZ,   target: AddrReduce};
      AddrSqInit:  w = '{accept: 1'b0, op: OP_SQ_FROM_Z,  cond: C_NEVER,    target: AddrFetch};
      AddrTest:    w = '{accept: 1'b0, op: OP_NONE,       cond: C_EXP_ZERO, target: AddrDone};
      AddrSetAcc:  w = '{accept: 1'b0, op: OP_SETUP_ACC,  cond: C_EXP_EVEN, target: AddrShift};
      AddrMulAcc:  w = '{accept: 1'b0, op: OP_MUL_STEP,   cond: C_CNT_NZ,   target: AddrMulAcc};
      AddrAccOut:  w = '{accept: 1'b0, op: OP_ACC_FROM_Z, cond: C_NEVER,    target: AddrFetch};
      AddrShift:   w = '{accept: 1'b0, op: OP_SHIFT_E,    cond: C_EXP_ONE,  target: AddrDone};
      AddrSetSq:   w = '{accept: 1'b0, op: OP_SETUP_SQ,   cond: C_NEVER,    target: AddrFetch};
      AddrMulSq:   w = '{accept: 1'b0, op: OP_MUL_STEP,   cond: C_CNT_NZ,   target: AddrMulSq};
      AddrSqOut:   w = '{accept: 1'b0, op: OP_SQ_FROM_Z,  cond: C_ALWAYS,   target: AddrSetAcc};
      AddrDone:    w = '{accept: 1'b0, op: OP_WRITE_OUT,  cond: C_OUT_FULL, target: AddrDone};
      AddrDoneRet: w = '{accept: 1'b0, op: OP_NONE,       cond: C_ALWAYS,   target: AddrFetch};
      AddrErr:     w = '{accept: 1'b0, op: OP_WRITE_ERR,  cond: C_OUT_FULL, target: AddrErr};
      AddrErrRet:  w = '{accept: 1'b0, op: OP_NONE,       cond: C_ALWAYS,   target: AddrFetch};
      default:     w = '{accept: 1'b0, op: OP_NONE,       cond: C_ALWAYS,   target: AddrFetch};
    endcase
    return w;
  endfunction

endpackage

[rtl/core/modular_exponentiation_unit.sv]
// top level of the modular exponentiation unit: base^exponent mod modulus
//
// input channel: in_valid_i / in_stall_o with base, exponent and modulus.
// the unit takes one operand set at a time; in_stall_o is low only while
// the sequencer waits at its fetch step.
// output channel: out_valid_o / out_stall_i with power_result_o and
// modulus_error_o, held in an output register, so a new operand set is
// taken while a finished result still waits for its transfer.
// a zero modulus returns with the error flag set and result 0. otherwise the
// base is first reduced mod the modulus, then each exponent bit takes up to
// two modular products plus a shift. the shift-add modular step does one add
// and two compares per bit of the multiplier.
// reset: the step counter returns to fetch and the output register empties.
// a stalled receiver holds the result; the program waits at its write step.
module modular_exponentiation_unit import mexp_pkg::*; #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [ResultWidth-1:0] base_value_i,
  input  logic [ResultWidth-1:0] exponent_value_i,
  input  logic [ResultWidth-1:0] modulus_value_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [ResultWidth-1:0] power_result_o,
  output logic                   modulus_error_o
);

  upc_t       upc;
  ctrl_word_t ctrl;
  dp_status_t status;

  mexp_ucode_rom u_rom (
    .upc_i  (upc),
    .ctrl_o (ctrl)
  );

  mexp_sequencer #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .status_i (status),
    .upc_o    (upc)
  );

  mexp_datapath #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctrl_i           (ctrl),
    .in_valid_i       (in_valid_i),
    .base_value_i     (base_value_i),
    .exponent_value_i (exponent_value_i),
    .modulus_value_i  (modulus_value_i),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .power_result_o   (power_result_o),
    .modulus_error_o  (modulus_error_o),
    .status_o         (status)
  );

  assign in_stall_o = !ctrl.accept;

endmodule

[rtl/core/mexp_ucode_rom.sv]
// microcode store: maps the step counter to its control word
module mexp_ucode_rom import mexp_pkg::*; (
  input  upc_t       upc_i,
  output ctrl_word_t ctrl_o
);

  assign ctrl_o = ucode_fetch(upc_i);

endmodule

[rtl/core/mexp_sequencer.sv]
// step counter, loop counter and conditional jump logic
module mexp_sequencer import mexp_pkg::*; #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ctrl_word_t ctrl_i,
  input  dp_status_t status_i,
  output upc_t       upc_o
);

  localparam int CntWidth = $clog2(OPERAND_WIDTH);
  localparam logic [CntWidth-1:0] CntLast = CntWidth'(OPERAND_WIDTH - 1);

  upc_t upc_q, upc_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic taken;

  always_comb begin
    taken = 1'b0;
    case (ctrl_i.cond)
      C_NEVER:    taken = 1'b0;
      C_ALWAYS:   taken = 1'b1;
      C_NO_IN:    taken = !status_i.in_valid;
      C_MOD_ZERO: taken = status_i.mod_zero;
      C_CNT_NZ:   taken = (cnt_q != '0);
      C_EXP_ZERO: taken = status_i.exp_zero;
      C_EXP_EVEN: taken = status_i.exp_even;
      C_EXP_ONE:  taken = status_i.exp_one;
      C_OUT_FULL: taken = status_i.out_full;
      default:    taken = 1'b0;
    endcase
  end

  always_comb begin
    upc_d = taken ? ctrl_i.target : upc_q + upc_t'(1);
    cnt_d = cnt_q;
    // loop counter counts down while looping, reloads on exit
    if (ctrl_i.cond == C_CNT_NZ) begin
      cnt_d = (cnt_q != '0) ? cnt_q - CntWidth'(1) : CntLast;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= AddrFetch;
      cnt_q <= CntLast;
    end else begin
      upc_q <= upc_d;
      cnt_q <= cnt_d;
    end
  end

  assign upc_o = upc_q;

endmodule

[rtl/core/mexp_datapath.sv]
// operand registers, shift-add modular step and output register
module mexp_datapath import mexp_pkg::*; #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ctrl_word_t             ctrl_i,
  input  logic                   in_valid_i,
  input  logic [ResultWidth-1:0] base_value_i,
  input  logic [ResultWidth-1:0] exponent_value_i,
  input  logic [ResultWidth-1:0] modulus_value_i,
  input  logic                   out_stall_i,
  output logic                   out_valid_o,
  output logic [ResultWidth-1:0] power_result_o,
  output logic                   modulus_error_o,
  output dp_status_t             status_o
);

  localparam int W = OPERAND_WIDTH;
  localparam int SumWidth = W + 2;

  logic [W-1:0] m_q, e_q, a_q, b_q, z_q, acc_q, sq_q;
  logic [W-1:0] z_next, addend;
  logic [SumWidth-1:0] sum, mod1, mod2, diff1, diff2;
  logic [ResultWidth-1:0] res_q;
  logic err_q, out_valid_q, out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  // 2z + addend lies below 3m, so one of three candidates is the residue
  always_comb begin
    if (ctrl_i.op == OP_RED_STEP) begin
      addend = b_q[W-1] ? W'(1) : '0;
    end else begin
      addend = b_q[W-1] ? a_q : '0;
    end
    sum   = SumWidth'({z_q, 1'b0}) + SumWidth'(addend);
    mod1  = SumWidth'(m_q);
    mod2  = SumWidth'({m_q, 1'b0});
    diff1 = sum - mod1;
    diff2 = sum - mod2;
    if (sum >= mod2) begin
      z_next = diff2[W-1:0];
    end else if (sum >= mod1) begin
      z_next = diff1[W-1:0];
    end else begin
      z_next = sum[W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    case (ctrl_i.op)
      OP_LOAD: begin
        if (in_valid_i) begin
          m_q <= W'(modulus_value_i);
          e_q <= W'(exponent_value_i);
          b_q <= W'(base_value_i);
          z_q <= '0;
        end
      end
      OP_INIT:       acc_q <= (m_q == W'(1)) ? '0 : W'(1);
      OP_RED_STEP,
      OP_MUL_STEP: begin
        z_q <= z_next;
        b_q <= {b_q[W-2:0], 1'b0};
      end
      OP_SQ_FROM_Z:  sq_q <= z_q;
      OP_ACC_FROM_Z: acc_q <= z_q;
      OP_SETUP_ACC: begin
        a_q <= acc_q;
        b_q <= sq_q;
        z_q <= '0;
      end
      OP_SETUP_SQ: begin
        a_q <= sq_q;
        b_q <= sq_q;
        z_q <= '0;
      end
      OP_SHIFT_E:    e_q <= {1'b0, e_q[W-1:1]};
      OP_WRITE_OUT: begin
        if (out_free) begin
          res_q <= ResultWidth'(acc_q);
          err_q <= 1'b0;
        end
      end
      OP_WRITE_ERR: begin
        if (out_free) begin
          res_q <= '0;
          err_q <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((ctrl_i.op == OP_WRITE_OUT || ctrl_i.op == OP_WRITE_ERR) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign power_result_o  = res_q;
  assign modulus_error_o = err_q;

  assign status_o = '{
    mod_zero: (m_q == '0),
    exp_zero: (e_q == '0),
    exp_even: !e_q[0],
    exp_one:  (e_q == W'(1)),
    in_valid: in_valid_i,
    out_full: out_valid_q && out_stall_i
  };

endmodule
